@@ sv/hmlm_pkg.sv @@
// Package: shared types and constants of the Hoare monitor lock manager.
package hmlm_pkg;

   // Process id width (ports and stored ids)
   localparam int ID_BITS = 8;

   // Defaults for the top-level parameters
   localparam int MAX_CONDITIONS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF    = 16;

   // Width of the condition count register
   localparam int NCOND_BITS = 4;

   // Fixed queue numbers; condition c lives in queue Q_COND0 + c
   localparam int Q_ENTRY  = 0;
   localparam int Q_URGENT = 1;
   localparam int Q_COND0  = 2;

   typedef enum logic [1:0] {
      MODE_ENTER  = 2'd0,
      MODE_LEAVE  = 2'd1,
      MODE_WAIT   = 2'd2,
      MODE_SIGNAL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CODE_OK      = 2'd0,
      CODE_REFUSED = 2'd1,
      CODE_FULL    = 2'd2
   } code_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

endpackage

@@ sv/hoare_monitor_lock_manager.sv @@
// Top level: Hoare monitor lock manager with queue storage in one synchronous memory.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+------------------------------
//   request  | req_mode, req_requester_id, req_condition_index | start && !busy
//   reply    | rsp_reply_to, rsp_reply_code, rsp_last          | rsp_strobe, one cycle each
//   config   | csr_wdata                                       | csr_we
//
// An item that pops a queue (leave or wait with waiters, signal with a waiter) reads
// the queue head from the FIFO memory, whose read data is registered, and grants the
// popped id in state ST_POP. Every other item completes without leaving ST_IDLE.
// A direct reply is on the ports in the cycle after acceptance; the grant of a popped id
// is registered from ST_POP, so after a leave it directly follows the leaver's reply.
// Reset is synchronous and clears the lock, the owner and all queue pointers and counts.
// The receiver cannot stall; busy is high only during the memory read cycle.
module hoare_monitor_lock_manager
   import hmlm_pkg::*;
#(
   parameter int MAX_CONDITIONS = MAX_CONDITIONS_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_mode,
   input  logic [ID_BITS-1:0]    req_requester_id,
   input  logic [2:0]            req_condition_index,
   output logic                  rsp_strobe,
   output logic [ID_BITS-1:0]    rsp_reply_to,
   output logic [1:0]            rsp_reply_code,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [NCOND_BITS-1:0] csr_wdata
);

   localparam int NUM_QUEUES = Q_COND0 + MAX_CONDITIONS;
   localparam int QW         = $clog2(NUM_QUEUES);
   localparam int SW         = $clog2(QUEUE_DEPTH);
   localparam int CW         = $clog2(QUEUE_DEPTH + 1);
   localparam int AW         = QW + SW;
   localparam int MEM_DEPTH  = NUM_QUEUES * (2 ** SW);

   localparam logic [QW-1:0] QI_ENTRY  = QW'(Q_ENTRY);
   localparam logic [QW-1:0] QI_URGENT = QW'(Q_URGENT);
   localparam logic [SW-1:0] SLOT_LAST = SW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL  = CW'(QUEUE_DEPTH);

   // Control and queue pointer registers
   state_type                state_ff, state_in;
   logic                     locked_ff, locked_in;
   logic [ID_BITS-1:0]       owner_ff, owner_in;
   logic [NCOND_BITS-1:0]    ncond_ff;
   logic [SW-1:0]            head_ff [NUM_QUEUES];
   logic [SW-1:0]            head_in [NUM_QUEUES];
   logic [SW-1:0]            tail_ff [NUM_QUEUES];
   logic [SW-1:0]            tail_in [NUM_QUEUES];
   logic [CW-1:0]            count_ff [NUM_QUEUES];
   logic [CW-1:0]            count_in [NUM_QUEUES];

   // Reply registers
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]       rsp_to_ff, rsp_to_in;
   code_type                 rsp_code_ff, rsp_code_in;
   logic                     rsp_last_ff, rsp_last_in;

   // FIFO memory
   logic [ID_BITS-1:0]       fifo_mem [MEM_DEPTH];
   logic [ID_BITS-1:0]       rd_data_ff;
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [AW-1:0]            mem_raddr;
   logic [ID_BITS-1:0]       mem_wdata;

   // Request decode
   logic                     accept;
   logic                     is_owner;
   logic                     cond_ok;
   logic [QW-1:0]            cond_q;
   logic                     waiters;
   logic [QW-1:0]            hand_q;
   logic                     push_en;
   logic [QW-1:0]            push_q;
   logic                     pop_en;
   logic [QW-1:0]            pop_q;

   assign accept   = start && (state_ff == ST_IDLE);
   assign is_owner = locked_ff && (owner_ff == req_requester_id);
   assign cond_ok  = ({1'b0, req_condition_index} < ncond_ff) &&
                     (32'(req_condition_index) < MAX_CONDITIONS);
   assign cond_q   = QW'(Q_COND0 + 32'(req_condition_index));
   assign waiters  = (count_ff[Q_URGENT] != '0) || (count_ff[Q_ENTRY] != '0);
   assign hand_q   = (count_ff[Q_URGENT] != '0) ? QI_URGENT : QI_ENTRY;

   // Decide the item, then apply one push and one pop to distinct queues
   always_comb begin
      state_in     = state_ff;
      locked_in    = locked_ff;
      owner_in     = owner_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_to_in    = rsp_to_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      push_en      = 1'b0;
      push_q       = QI_ENTRY;
      pop_en       = 1'b0;
      pop_q        = QI_ENTRY;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = req_requester_id;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_to_in   = req_requester_id;
               rsp_code_in = CODE_OK;
               rsp_last_in = 1'b1;
               if (mode_type'(req_mode) == MODE_ENTER) begin
                  priority if (!locked_ff) begin
                     locked_in    = 1'b1;
                     owner_in     = req_requester_id;
                     rsp_valid_in = 1'b1;
                  end else if (count_ff[Q_ENTRY] == CNT_FULL) begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = CODE_FULL;
                  end else begin
                     push_en = 1'b1;
                     push_q  = QI_ENTRY;
                  end
               end else if (!is_owner ||
                            (mode_type'(req_mode) != MODE_LEAVE && !cond_ok)) begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = CODE_REFUSED;
               end else begin
                  unique case (mode_type'(req_mode))
                     MODE_LEAVE: begin
                        rsp_valid_in = 1'b1;
                        if (waiters) begin
                           rsp_last_in = 1'b0;
                           pop_en      = 1'b1;
                           pop_q       = hand_q;
                           state_in    = ST_POP;
                        end else begin
                           locked_in = 1'b0;
                           owner_in  = '0;
                        end
                     end
                     MODE_WAIT: begin
                        if (count_ff[cond_q] == CNT_FULL) begin
                           rsp_valid_in = 1'b1;
                           rsp_code_in  = CODE_FULL;
                        end else begin
                           push_en = 1'b1;
                           push_q  = cond_q;
                           if (waiters) begin
                              pop_en   = 1'b1;
                              pop_q    = hand_q;
                              state_in = ST_POP;
                           end else begin
                              locked_in = 1'b0;
                              owner_in  = '0;
                           end
                        end
                     end
                     MODE_SIGNAL: begin
                        priority if (count_ff[cond_q] == '0) begin
                           rsp_valid_in = 1'b1;
                        end else if (count_ff[Q_URGENT] == CNT_FULL) begin
                           rsp_valid_in = 1'b1;
                           rsp_code_in  = CODE_FULL;
                        end else begin
                           push_en  = 1'b1;
                           push_q   = QI_URGENT;
                           pop_en   = 1'b1;
                           pop_q    = cond_q;
                           state_in = ST_POP;
                        end
                     end
                     default: begin
                        rsp_valid_in = 1'b0;
                     end
                  endcase
               end
            end
         end
         ST_POP: begin
            // Grant the popped id
            locked_in    = 1'b1;
            owner_in     = rd_data_ff;
            rsp_valid_in = 1'b1;
            rsp_to_in    = rd_data_ff;
            rsp_code_in  = CODE_OK;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Append at the tail
      if (push_en) begin
         mem_we           = 1'b1;
         mem_waddr        = {push_q, tail_ff[push_q]};
         tail_in[push_q]  = (tail_ff[push_q] == SLOT_LAST) ? '0 : tail_ff[push_q] + 1'b1;
         count_in[push_q] = count_ff[push_q] + 1'b1;
      end

      // Read the head and advance it
      if (pop_en) begin
         mem_raddr       = {pop_q, head_ff[pop_q]};
         head_in[pop_q]  = (head_ff[pop_q] == SLOT_LAST) ? '0 : head_ff[pop_q] + 1'b1;
         count_in[pop_q] = count_ff[pop_q] - 1'b1;
      end
   end

   // Hold control state and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         locked_ff    <= 1'b0;
         owner_ff     <= '0;
         ncond_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         locked_ff    <= locked_in;
         owner_ff     <= owner_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         if (csr_we) begin
            ncond_ff <= csr_wdata;
         end
      end
   end

   // Hold the reply payload
   always_ff @(posedge clock) begin
      rsp_to_ff   <= rsp_to_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Write and read the FIFO memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fifo_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= fifo_mem[mem_raddr];
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_reply_to   = rsp_to_ff;
   assign rsp_reply_code = rsp_code_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ sv/hmlm_checker.sv @@
// Checker: port-level properties of the lock manager, bound to the top level.
module hmlm_checker
   import hmlm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_reply_code,
   input logic               rsp_last
);

   // A first reply of two is always followed by the final one
   a_pair_completes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe && rsp_last)
      else $error("first reply not followed by final reply");

   // The first of two replies goes out while the block is busy with the head read
   a_pair_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("first reply of two outside the read cycle");

   // Busy lasts a single cycle and only follows an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      busy |-> $past(start) && !$past(busy))
      else $error("busy without an accepted item");

   // A second reply is always a grant
   a_second_is_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_reply_code == CODE_OK)
      else $error("second reply is not a grant");

   // Reset leaves the block idle and quiet
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

endmodule

bind hoare_monitor_lock_manager hmlm_checker u_hmlm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_reply_code (rsp_reply_code),
   .rsp_last       (rsp_last)
);
